FILE: rtl/delay_doppler_histogram_core_macros.svh
// Assertion macros shared by the delay-Doppler histogram RTL.
// No dependencies; included by the top level only.
`ifndef DELAY_DOPPLER_HISTOGRAM_CORE_MACROS_SVH
`define DELAY_DOPPLER_HISTOGRAM_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DDH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ddh_pkg.sv
// Shared types and constants of the delay-Doppler histogram core.
// No dependencies.
package ddh_pkg;

  localparam int CellW = 36;
  localparam int ValW  = 17;
  localparam int QuoW  = 15;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACC   = 2'd1,
    OP_MAX   = 2'd2,
    OP_READ  = 2'd3
  } ddh_op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SKIP  = 2'd1,
    STAT_NOPOS = 2'd2
  } ddh_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC,
    S_WALK,
    S_READ,
    S_DIV,
    S_FIN
  } ddh_state_e;

  // Classification of one command, made by the front end.
  typedef struct packed {
    ddh_op_e op;
    logic    skip;
    logic    oob;
  } ddh_ctrl_t;

  localparam logic signed [CellW-1:0] CellMax = {1'b0, {(CellW-1){1'b1}}};
  localparam logic signed [CellW-1:0] CellMin = {1'b1, {(CellW-1){1'b0}}};
  localparam logic [ValW-1:0] ValPosSat = 17'h08000;
  localparam logic [ValW-1:0] ValNegSat = 17'h18000;

endpackage

FILE: rtl/ddh_front.sv
// Front end: accepts commands and maps a pixel to its grid cell address.
// Depends on ddh_pkg.
module ddh_front #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64,
  parameter int AW          = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               hold_i,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] radial_velocity_i,
  input  logic [15:0]        depth_i,
  input  logic signed [15:0] weight_i,
  input  logic [11:0]        cell_index_i,
  input  logic               full_i,
  output logic               busy_o,
  output logic               push_o,
  output ddh_pkg::ddh_ctrl_t ctrl_o,
  output logic signed [15:0] weight_o,
  output logic [AW-1:0]      addr_o
);
  import ddh_pkg::*;

  localparam int Cells = GRID_WIDTH * GRID_HEIGHT;
  localparam int WW    = $clog2(GRID_WIDTH + 1);
  localparam int HW    = $clog2(GRID_HEIGHT + 1);
  localparam int IW    = (AW > 12) ? AW : 12;
  localparam int LW    = WW + HW + 1;

  logic               s1_v_q, s2_v_q;
  ddh_op_e            s1_op_q, s2_op_q;
  logic [15:0]        s1_vel_q, s1_dep_q;
  logic signed [15:0] s1_w_q, s2_w_q;
  logic [IW-1:0]      s1_idx_q, s2_idx_q;
  logic [WW-1:0]      s2_col_q;
  logic [HW-1:0]      s2_row_q;
  logic               s2_skip_q, s2_oob_q;

  logic               s1_go, s2_go, accept;
  logic [WW+15:0]     colp;
  logic [HW+15:0]     rowp;
  logic [WW-1:0]      col_c;
  logic [HW-1:0]      row_c;
  logic [LW-1:0]      lin;

  assign s2_go  = s2_v_q && !full_i;
  assign s1_go  = s1_v_q && (!s2_v_q || s2_go);
  assign busy_o = hold_i || (s1_v_q && !s1_go);
  assign accept = start_i && !busy_o;

  // Column and row scale the fractions by the grid size.
  assign colp  = (WW + 16)'(GRID_WIDTH) * (WW + 16)'(s1_vel_q);
  assign rowp  = (HW + 16)'(GRID_HEIGHT) * (HW + 16)'(s1_dep_q);
  assign col_c = colp[WW+15:16];
  assign row_c = rowp[HW+15:16];

  assign lin = LW'(s2_row_q) * LW'(GRID_WIDTH) + LW'(s2_col_q);

  assign push_o        = s2_go;
  assign ctrl_o.op     = s2_op_q;
  assign ctrl_o.skip   = s2_skip_q;
  assign ctrl_o.oob    = s2_oob_q;
  assign weight_o      = s2_w_q;
  assign addr_o        = (s2_op_q == OP_READ) ? s2_idx_q[AW-1:0] : lin[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go) begin
        s2_v_q <= 1'b1;
      end else if (s2_go) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= ddh_op_e'(operation_i);
      s1_vel_q <= {~radial_velocity_i[15], radial_velocity_i[14:0]};
      s1_dep_q <= depth_i;
      s1_w_q   <= weight_i;
      s1_idx_q <= IW'(cell_index_i);
    end
    if (s1_go) begin
      s2_op_q   <= s1_op_q;
      s2_w_q    <= s1_w_q;
      s2_idx_q  <= s1_idx_q;
      s2_col_q  <= col_c;
      s2_row_q  <= row_c;
      s2_skip_q <= (s1_dep_q == 16'd0) || (col_c >= WW'(GRID_WIDTH))
                   || (row_c >= HW'(GRID_HEIGHT));
      s2_oob_q  <= (IW + 1)'(s1_idx_q) >= (IW + 1)'(Cells);
    end
  end

endmodule

FILE: rtl/ddh_fifo.sv
// Two-entry command queue between the front and back ends.
// Depends on nothing.
module ddh_fifo #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] din_i,
  input  logic          pop_i,
  output logic [DW-1:0] dout_o,
  output logic          empty_o,
  output logic          full_o
);
  logic [DW-1:0] slot_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign dout_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= din_i;
    end
  end

endmodule

FILE: rtl/ddh_back.sv
// Back end: grid memory, clear sweep, maximum walk and normalizing divider.
// Depends on ddh_pkg.
module ddh_back #(
  parameter int CELLS = 4096,
  parameter int AW    = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  ddh_pkg::ddh_ctrl_t ctrl_i,
  input  logic signed [15:0] weight_i,
  input  logic [AW-1:0]      addr_i,
  output logic               pop_o,
  output logic               init_o,
  output logic               valid_o,
  output logic [16:0]        value_o,
  output logic [1:0]         status_o
);
  import ddh_pkg::*;

  logic signed [CellW-1:0] mem [CELLS];
  logic signed [CellW-1:0] rdata_q;

  ddh_state_e              state_q, state_d;
  logic [AW:0]             cnt_q, cnt_d;
  logic [3:0]              dcnt_q, dcnt_d;
  logic                    clr_res_q, clr_res_d;
  logic [AW-1:0]           addr_q, addr_d;
  logic signed [15:0]      w_q, w_d;
  logic                    oob_q, oob_d;
  logic signed [CellW-1:0] max_q, max_d;
  logic                    first_q, first_d, rv_q, rv_d;
  logic [CellW-1:0]        rem_q, rem_d;
  logic [QuoW-1:0]         quo_q, quo_d;
  logic                    neg_q, neg_d;
  logic                    valid_q, valid_d;
  logic [ValW-1:0]         value_q, value_d;
  ddh_status_e             status_q, status_d;

  logic                    we, pop;
  logic [AW-1:0]           waddr, raddr;
  logic signed [CellW-1:0] wdata;
  logic signed [CellW:0]   sum;
  logic signed [CellW-1:0] sat, rd_cell, mx_n;
  logic signed [CellW:0]   negmax;
  logic [CellW:0]          rem2, rem2s;
  logic                    more, last_clr, divide, go_cell;

  assign sum      = CellW'(0) + {rdata_q[CellW-1], rdata_q} + (CellW + 1)'(w_q);
  assign sat      = (sum[CellW] != sum[CellW-1]) ? (sum[CellW] ? CellMin : CellMax)
                                                 : sum[CellW-1:0];
  assign more     = cnt_q < (AW + 1)'(CELLS);
  assign last_clr = cnt_q == (AW + 1)'(CELLS - 1);
  assign mx_n     = (first_q || (rdata_q > max_q)) ? rdata_q : max_q;
  assign rd_cell  = oob_q ? '0 : rdata_q;
  assign negmax   = -{max_q[CellW-1], max_q};
  assign go_cell  = (rd_cell < max_q) && ($signed({rd_cell[CellW-1], rd_cell}) > negmax);
  assign divide   = (max_q > 0) && go_cell;
  assign rem2     = {rem_q, 1'b0};
  assign rem2s    = rem2 - {1'b0, max_q};

  assign pop_o    = pop;
  assign init_o   = (state_q == S_CLEAR) && !clr_res_q;
  assign valid_o  = valid_q;
  assign value_o  = value_q;
  assign status_o = status_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (last_clr) state_d = S_IDLE;
      S_IDLE: begin
        if (!empty_i) begin
          unique case (ctrl_i.op)
            OP_CLEAR: state_d = S_CLEAR;
            OP_ACC:   state_d = ctrl_i.skip ? S_IDLE : S_ACC;
            OP_MAX:   state_d = S_WALK;
            OP_READ:  state_d = S_READ;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_ACC:  state_d = S_IDLE;
      S_WALK: if (!more && rv_q) state_d = S_IDLE;
      S_READ: state_d = divide ? S_DIV : S_IDLE;
      S_DIV:  if (dcnt_q == 4'(QuoW - 1)) state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    dcnt_d    = dcnt_q;
    clr_res_d = clr_res_q;
    addr_d    = addr_q;
    w_d       = w_q;
    oob_d     = oob_q;
    max_d     = max_q;
    first_d   = first_q;
    rv_d      = rv_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    neg_d     = neg_q;
    valid_d   = 1'b0;
    value_d   = value_q;
    status_d  = status_q;
    pop       = 1'b0;
    we        = 1'b0;
    waddr     = addr_q;
    wdata     = sat;
    raddr     = addr_q;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q[AW-1:0];
        wdata = '0;
        max_d = '0;
        cnt_d = cnt_q + 1'b1;
        if (last_clr && clr_res_q) begin
          valid_d  = 1'b1;
          value_d  = '0;
          status_d = STAT_OK;
        end
      end
      S_IDLE: begin
        raddr = addr_i;
        if (!empty_i) begin
          pop    = 1'b1;
          addr_d = addr_i;
          w_d    = weight_i;
          oob_d  = ctrl_i.oob;
          unique case (ctrl_i.op)
            OP_CLEAR: begin
              cnt_d     = '0;
              clr_res_d = 1'b1;
            end
            OP_ACC: begin
              if (ctrl_i.skip) begin
                valid_d  = 1'b1;
                value_d  = '0;
                status_d = STAT_SKIP;
              end
            end
            OP_MAX: begin
              cnt_d   = '0;
              rv_d    = 1'b0;
              first_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_ACC: begin
        we       = 1'b1;
        valid_d  = 1'b1;
        value_d  = '0;
        status_d = STAT_OK;
      end
      S_WALK: begin
        // Reads issue one cell per cycle; the compare uses the registered read data in the following cycle.
        raddr = cnt_q[AW-1:0];
        rv_d  = more;
        if (more) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (rv_q) begin
          max_d   = mx_n;
          first_d = 1'b0;
          if (!more) begin
            valid_d  = 1'b1;
            value_d  = '0;
            status_d = (mx_n > 0) ? STAT_OK : STAT_NOPOS;
          end
        end
      end
      S_READ: begin
        dcnt_d = '0;
        rem_d  = rd_cell[CellW-1] ? CellW'(-rd_cell) : rd_cell;
        quo_d  = '0;
        neg_d  = rd_cell[CellW-1];
        if (!(max_q > 0)) begin
          valid_d  = 1'b1;
          value_d  = '0;
          status_d = STAT_NOPOS;
        end else if (!go_cell) begin
          valid_d  = 1'b1;
          value_d  = rd_cell[CellW-1] ? ValNegSat : ValPosSat;
          status_d = STAT_OK;
        end
      end
      S_DIV: begin
        dcnt_d = dcnt_q + 4'd1;
        if (!rem2s[CellW]) begin
          rem_d = rem2s[CellW-1:0];
          quo_d = {quo_q[QuoW-2:0], 1'b1};
        end else begin
          rem_d = rem2[CellW-1:0];
          quo_d = {quo_q[QuoW-2:0], 1'b0};
        end
      end
      S_FIN: begin
        // A negative quotient rounds toward minus infinity.
        valid_d  = 1'b1;
        status_d = STAT_OK;
        value_d  = neg_q ? (ValW'(0) - ValW'(quo_q) - ValW'(rem_q != '0))
                         : ValW'(quo_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      clr_res_q <= 1'b0;
      valid_q   <= 1'b0;
      max_q     <= '0;
      rv_q      <= 1'b0;
      first_q   <= 1'b0;
      dcnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      clr_res_q <= (state_q == S_CLEAR && last_clr) ? 1'b0 : clr_res_d;
      valid_q   <= valid_d;
      max_q     <= max_d;
      rv_q      <= rv_d;
      first_q   <= first_d;
      dcnt_q    <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    w_q      <= w_d;
    oob_q    <= oob_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    neg_q    <= neg_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

endmodule

FILE: rtl/delay_doppler_histogram_core.sv
// Delay-Doppler histogram core: weighted 2D grid with normalized readout.
// Depends on ddh_pkg, ddh_front, ddh_fifo, ddh_back and the macros header.
// Each command passes the front stages and the queue before it reaches the back end; the back end
// takes a new pixel only after it has finished the last one.
// Reset clears the grid in one pass over all GRID_WIDTH*GRID_HEIGHT cells with busy high.
// Each result is a one-cycle strobe; the receiver cannot stall it.
`include "delay_doppler_histogram_core_macros.svh"
module delay_doppler_histogram_core #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] radial_velocity_i,
  input  logic [15:0]        depth_i,
  input  logic signed [15:0] weight_i,
  input  logic [11:0]        cell_index_i,
  output logic               valid_o,
  output logic signed [16:0] value_o,
  output logic [1:0]         status_o
);
  import ddh_pkg::*;

  // The grid holds one 36-bit saturating sum per cell, row-major.
  localparam int Cells = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(Cells);
  localparam int QW    = $bits(ddh_ctrl_t) + 16 + AW;

  logic               init;
  logic               push, pop, empty, full;
  ddh_ctrl_t          f_ctrl, b_ctrl;
  logic signed [15:0] f_w, b_w;
  logic [AW-1:0]      f_addr, b_addr;
  logic [QW-1:0]      q_in, q_out;
  logic [16:0]        value;
  logic               res_nz, res_nopos;

  // The front end computes the cell address of a pixel over two stages.
  ddh_front #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .hold_i           (init),
    .operation_i      (operation_i),
    .radial_velocity_i(radial_velocity_i),
    .depth_i          (depth_i),
    .weight_i         (weight_i),
    .cell_index_i     (cell_index_i),
    .full_i           (full),
    .busy_o           (busy_o),
    .push_o           (push),
    .ctrl_o           (f_ctrl),
    .weight_o         (f_w),
    .addr_o           (f_addr)
  );

  // The queue lets the front end run ahead while the back end works.
  assign q_in = {f_ctrl, f_w, f_addr};
  assign {b_ctrl, b_w, b_addr} = q_out;

  ddh_fifo #(
    .DW(QW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .din_i  (q_in),
    .pop_i  (pop),
    .dout_o (q_out),
    .empty_o(empty),
    .full_o (full)
  );

  // The back end owns the grid memory and produces every result beat.
  ddh_back #(
    .CELLS(Cells),
    .AW   (AW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .ctrl_i  (b_ctrl),
    .weight_i(b_w),
    .addr_i  (b_addr),
    .pop_o   (pop),
    .init_o  (init),
    .valid_o (valid_o),
    .value_o (value),
    .status_o(status_o)
  );

  assign value_o = $signed(value);

  assign res_nz    = valid_o && (value_o != 17'sd0);
  assign res_nopos = valid_o && (status_o == STAT_NOPOS);

  // A nonzero quotient only comes with a good status.
  `DDH_ASSERT_NOW(a_value_ok, clk_i, rst_ni, res_nz, status_o == STAT_OK, "bad status")
  // A maximum that is not positive always reads as zero.
  `DDH_ASSERT_NOW(a_nopos_zero, clk_i, rst_ni, res_nopos, value_o == 17'sd0, "nonzero value")
  // The clearing pass after reset emits no result beat.
  `DDH_ASSERT_NEXT(a_init_quiet, clk_i, rst_ni, init, !valid_o, "beat during reset clear")

endmodule
